// ===== hw/rtl/sliding_window_share_rate_assert.svh =====
// assertion macros used by the checker file
`ifndef SLIDING_WINDOW_SHARE_RATE_ASSERT_SVH
`define SLIDING_WINDOW_SHARE_RATE_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define SWSR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define SWSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/swsr_pkg.sv =====
// ----------------------------------------------------------------------------
// swsr_pkg
// Types and constants of the sliding window share rate block.
// ----------------------------------------------------------------------------
package swsr_pkg;

   // ring store depth, a power of two so a counter selects a slot by its low bits
   localparam int RING_DEPTH = 4096;
   localparam int RING_AW    = $clog2(RING_DEPTH);

   localparam int NWIN      = 3;
   localparam int CNT_W     = 32;
   localparam int DIFF_W    = 32;
   localparam int TS_W      = 48;
   localparam int SPAN_W    = 32;
   localparam int RATE_W    = 40;
   localparam int SUM_W     = 64;
   localparam int DEN_W     = 58;
   localparam int STEP_W    = 6;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SPAN_SHORT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN_MID   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN_LONG  = 2'd2;

   localparam logic [SPAN_W-1:0] SPAN_SHORT_RST = 32'd600000;
   localparam logic [SPAN_W-1:0] SPAN_MID_RST   = 32'd3600000;
   localparam logic [SPAN_W-1:0] SPAN_LONG_RST  = 32'd86400000;

   localparam logic [RATE_W-1:0] RATE_MAX  = {RATE_W{1'b1}};
   localparam logic [STEP_W-1:0] DIV_LAST  = 6'd39;

   typedef logic [1:0] win_idx_type;

   localparam win_idx_type WIN_SHORT = 2'd0;
   localparam win_idx_type WIN_LONG  = 2'd2;

   typedef struct packed {
      logic [DIFF_W-1:0] share_difficulty;
      logic [TS_W-1:0]   timestamp_ms;
   } req_type;

   typedef struct packed {
      logic [RATE_W-1:0] rate_short;
      logic [RATE_W-1:0] rate_mid;
      logic [RATE_W-1:0] rate_long;
      logic              held_short;
      logic              held_mid;
      logic              held_long;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic        push;
      logic        adv_rd;
      logic        new_ld;
      logic        trim_rd;
      logic        trim_ld;
      logic        den_ld;
      logic        div_init;
      logic        div_step;
      logic        st_hold;
      logic        st_sat;
      logic        st_quot;
      logic        out_ld;
      win_idx_type win;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic trim_stop;
      logic hold;
      logic sat;
      logic div_last;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== hw/rtl/swsr_ram.sv =====
// ----------------------------------------------------------------------------
// swsr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module swsr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/swsr_dp.sv =====
// ----------------------------------------------------------------------------
// swsr_dp
// Datapath: ring store, window pointers and sums, divider and result register.
// ----------------------------------------------------------------------------
module swsr_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  swsr_pkg::dp_cmd_type              cmd,
   output swsr_pkg::dp_stat_type             stat,
   input  swsr_pkg::req_type                 req_data,
   input  logic                              csr_we,
   input  logic [swsr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [swsr_pkg::SPAN_W-1:0]       csr_wdata,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output swsr_pkg::rsp_type                 rsp_data
);
   import swsr_pkg::*;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  first_ff [NWIN];
   logic [CNT_W-1:0]  last_ff  [NWIN];
   logic [SUM_W-1:0]  sum_ff   [NWIN];
   logic [RATE_W-1:0] rate_ff  [NWIN];
   logic [NWIN-1:0]   held_ff;
   logic [SPAN_W-1:0] span_ff  [NWIN];
   logic              adv_ff;
   logic [TS_W-1:0]   tnew_ff;
   logic [TS_W-1:0]   told_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [RATE_W-1:0] quot_ff;
   logic [RATE_W-1:0] low_ff;
   logic [STEP_W-1:0] step_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic [RING_AW-1:0] raddr;
   logic [DIFF_W-1:0]  rd_share;
   logic [TS_W-1:0]    rd_time;
   logic [CNT_W-1:0]   cur_first;
   logic [CNT_W-1:0]   cur_last;
   logic [CNT_W-1:0]   last_inc;
   logic [SUM_W-1:0]   cur_sum;
   logic [SPAN_W-1:0]  cur_span;
   logic               adv;
   logic [TS_W-1:0]    trim_diff;
   logic [TS_W-1:0]    win_diff;
   logic [TS_W-1:0]    dur;
   logic [DEN_W-1:0]   dur_ext;
   logic [DEN_W-1:0]   den_in;
   logic [DEN_W:0]     trial;
   logic               trial_ge;

   // ring store
   swsr_ram #(.WIDTH(DIFF_W), .DEPTH(RING_DEPTH)) u_share_ram (
      .clock (clock),
      .we    (cmd.push),
      .waddr (count_ff[RING_AW-1:0]),
      .wdata (req_data.share_difficulty),
      .raddr (raddr),
      .rdata (rd_share)
   );

   swsr_ram #(.WIDTH(TS_W), .DEPTH(RING_DEPTH)) u_time_ram (
      .clock (clock),
      .we    (cmd.push),
      .waddr (count_ff[RING_AW-1:0]),
      .wdata (req_data.timestamp_ms),
      .raddr (raddr),
      .rdata (rd_time)
   );

   // current window view
   always_comb begin
      cur_first = first_ff[cmd.win];
      cur_last  = last_ff[cmd.win];
      cur_sum   = sum_ff[cmd.win];
      cur_span  = span_ff[cmd.win];
      last_inc  = cur_last + 1'b1;
      adv       = (last_inc != count_ff);
      if (cmd.trim_rd) begin
         raddr = cur_first[RING_AW-1:0];
      end else if (adv) begin
         raddr = last_inc[RING_AW-1:0];
      end else begin
         raddr = cur_last[RING_AW-1:0];
      end
   end

   // span checks and divisor
   always_comb begin
      trim_diff = tnew_ff - rd_time;
      win_diff  = tnew_ff - told_ff;
      dur       = ({{(TS_W-SPAN_W){1'b0}}, cur_span} > win_diff) ?
                  {{(TS_W-SPAN_W){1'b0}}, cur_span} : win_diff;
      dur_ext   = {{(DEN_W-TS_W){1'b0}}, dur};
      // times 1000 as 1024 - 16 - 8
      den_in    = (dur_ext << 10) - (dur_ext << 4) - (dur_ext << 3);
      trial     = {rem_ff, low_ff[RATE_W-1]};
      trial_ge  = (trial >= {1'b0, den_ff});
   end

   assign stat.trim_stop = (trim_diff < {{(TS_W-SPAN_W){1'b0}}, cur_span}) ||
                           (cur_first == cur_last);
   assign stat.hold      = cur_sum[SUM_W-1] || (tnew_ff == told_ff);
   assign stat.sat       = ({2'b00, cur_sum[SUM_W-1:8]} >= den_ff);
   assign stat.div_last  = (step_ff == DIV_LAST);
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   // span registers
   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff[WIN_SHORT] <= SPAN_SHORT_RST;
         span_ff[1]         <= SPAN_MID_RST;
         span_ff[WIN_LONG]  <= SPAN_LONG_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SPAN_SHORT: span_ff[0] <= csr_wdata;
            CSR_SPAN_MID:   span_ff[1] <= csr_wdata;
            CSR_SPAN_LONG:  span_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // window state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         held_ff  <= '0;
         for (int i = 0; i < NWIN; i++) begin
            first_ff[i] <= '0;
            last_ff[i]  <= '0;
            sum_ff[i]   <= '0;
            rate_ff[i]  <= '0;
         end
      end else begin
         if (cmd.push) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.adv_rd && adv) begin
            last_ff[cmd.win] <= last_inc;
         end
         if (cmd.new_ld && adv_ff) begin
            sum_ff[cmd.win] <= cur_sum + {{(SUM_W-DIFF_W){1'b0}}, rd_share};
         end
         if (cmd.trim_ld && !stat.trim_stop) begin
            sum_ff[cmd.win]   <= cur_sum - {{(SUM_W-DIFF_W){1'b0}}, rd_share};
            first_ff[cmd.win] <= cur_first + 1'b1;
         end
         if (cmd.st_hold) begin
            held_ff[cmd.win] <= 1'b1;
         end
         if (cmd.st_sat) begin
            held_ff[cmd.win] <= 1'b0;
            rate_ff[cmd.win] <= RATE_MAX;
         end
         if (cmd.st_quot) begin
            held_ff[cmd.win] <= 1'b0;
            rate_ff[cmd.win] <= quot_ff;
         end
      end
   end

   // timestamps and divider
   always_ff @(posedge clock) begin
      if (cmd.adv_rd) begin
         adv_ff <= adv;
      end
      if (cmd.new_ld) begin
         tnew_ff <= rd_time;
      end
      if (cmd.trim_ld) begin
         told_ff <= rd_time;
      end
      if (cmd.den_ld) begin
         den_ff <= den_in;
      end
      if (cmd.div_init) begin
         rem_ff  <= {2'b00, cur_sum[SUM_W-1:8]};
         low_ff  <= {cur_sum[7:0], 32'd0};
         quot_ff <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= trial_ge ? trial[DEN_W-1:0] - den_ff : trial[DEN_W-1:0];
         low_ff  <= {low_ff[RATE_W-2:0], 1'b0};
         quot_ff <= {quot_ff[RATE_W-2:0], trial_ge};
         step_ff <= step_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_ld) begin
         rsp_data_ff.rate_short <= rate_ff[0];
         rsp_data_ff.rate_mid   <= rate_ff[1];
         rsp_data_ff.rate_long  <= rate_ff[2];
         rsp_data_ff.held_short <= held_ff[0];
         rsp_data_ff.held_mid   <= held_ff[1];
         rsp_data_ff.held_long  <= held_ff[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/swsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// swsr_ctrl
// Sequencer: walks the three windows, trims them and runs the divider.
// ----------------------------------------------------------------------------
module swsr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output swsr_pkg::dp_cmd_type  cmd,
   input  swsr_pkg::dp_stat_type stat
);
   import swsr_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ADV  = 4'd1;
   localparam logic [3:0] S_NEW  = 4'd2;
   localparam logic [3:0] S_TRD  = 4'd3;
   localparam logic [3:0] S_TLD  = 4'd4;
   localparam logic [3:0] S_DEN  = 4'd5;
   localparam logic [3:0] S_SAT  = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_STQ  = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   logic [3:0]  state_ff;
   logic [3:0]  state_in;
   win_idx_type win_ff;
   win_idx_type win_in;
   logic        win_done;

   assign req_stall = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      win_in   = win_ff;
      win_done = 1'b0;
      cmd      = '0;
      cmd.win  = win_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.push = 1'b1;
               win_in   = WIN_SHORT;
               state_in = S_ADV;
            end
         end
         S_ADV: begin
            cmd.adv_rd = 1'b1;
            state_in   = S_NEW;
         end
         S_NEW: begin
            cmd.new_ld = 1'b1;
            state_in   = S_TRD;
         end
         S_TRD: begin
            cmd.trim_rd = 1'b1;
            state_in    = S_TLD;
         end
         S_TLD: begin
            cmd.trim_ld = 1'b1;
            state_in    = stat.trim_stop ? S_DEN : S_TRD;
         end
         S_DEN: begin
            if (stat.hold) begin
               cmd.st_hold = 1'b1;
               win_done    = 1'b1;
            end else begin
               cmd.den_ld = 1'b1;
               state_in   = S_SAT;
            end
         end
         S_SAT: begin
            if (stat.sat) begin
               cmd.st_sat = 1'b1;
               win_done   = 1'b1;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_STQ;
            end
         end
         S_STQ: begin
            cmd.st_quot = 1'b1;
            win_done    = 1'b1;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.out_ld = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // move to the next window or to the result
      if (win_done) begin
         if (win_ff == WIN_LONG) begin
            state_in = S_OUT;
         end else begin
            win_in   = win_ff + 1'b1;
            state_in = S_ADV;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         win_ff   <= WIN_SHORT;
      end else begin
         state_ff <= state_in;
         win_ff   <= win_in;
      end
   end

endmodule

// ===== hw/rtl/sliding_window_share_rate.sv =====
// ----------------------------------------------------------------------------
// sliding_window_share_rate
// Share rate over three sliding time windows, reported in MH/s.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_data carries one share request: difficulty and
//   millisecond timestamp. rsp_valid/rsp_stall/rsp_data returns one result
//   per request: the three window rates and their held flags.
//   csr_we/csr_index/csr_wdata writes the window spans (0 short, 1 mid,
//   2 long); write only while no request is in flight.
//   Each request walks the three windows in turn. Each trimmed share costs a
//   ring read and a load; each window that is neither held nor saturated
//   runs a division on the shared bit-serial divider. One request is
//   processed at a time.
//   A finished result sits in the output register; the next request is
//   accepted while it waits, and the sequencer waits at its end if the
//   previous result is still stalled.
//   Reset clears pointers, sums, rates and spans to their defaults; the ring
//   store is not cleared since every slot is written before it is read.
// ----------------------------------------------------------------------------
module sliding_window_share_rate (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  swsr_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output swsr_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [swsr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [swsr_pkg::SPAN_W-1:0]    csr_wdata
);
   import swsr_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer
   swsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // datapath
   swsr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/swsr_checker.sv =====
// ----------------------------------------------------------------------------
// swsr_checker
// Port-level checks of the sliding window share rate block.
// ----------------------------------------------------------------------------
`include "sliding_window_share_rate_assert.svh"

module swsr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input swsr_pkg::rsp_type rsp_data
);
   import swsr_pkg::*;

   logic req_acc;

   assign req_acc = req_valid && !req_stall;

   // a stalled result holds
   `SWSR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // busy right after taking a request
   `SWSR_ASSERT_NEXT(a_busy_after_req, clock, reset, req_acc, req_stall)

   // a result never appears in the cycle after a request
   `SWSR_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_acc, !$rose(rsp_valid))

endmodule

bind sliding_window_share_rate swsr_checker u_swsr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding window share rate block: random and
// directed share requests with random gaps, span changes between phases,
// random result stalls, results compared field by field with an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;
   import swsr_pkg::*;

   typedef enum logic [1:0] {STEP_SHARE, STEP_DRAIN, STEP_SPAN} plan_kind_type;

   typedef struct {
      plan_kind_type           kind;
      req_type                 share;
      int                      gap;
      logic [CSR_IDX_W-1:0]    idx;
      logic [SPAN_W-1:0]       val;
   } plan_entry_type;

   localparam int SETTLE_CYCLES = 400;

   logic                  clock;
   logic                  reset;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [SPAN_W-1:0]     csr_wdata = '0;

   plan_entry_type share_plan_q[$];
   rsp_type        rate_expect_q[$];
   int             error_count = 0;

   // predictor state
   logic [DIFF_W-1:0] share_mem [RING_DEPTH];
   logic [TS_W-1:0]   time_mem  [RING_DEPTH];
   logic [CNT_W-1:0]  pushed_count = '0;
   logic [CNT_W-1:0]  win_first [NWIN] = '{default: '0};
   logic [CNT_W-1:0]  win_last  [NWIN] = '{default: '0};
   logic [SUM_W-1:0]  win_sum   [NWIN] = '{default: '0};
   logic [RATE_W-1:0] win_rate  [NWIN] = '{default: '0};
   logic [SPAN_W-1:0] win_span  [NWIN] = '{SPAN_SHORT_RST, SPAN_MID_RST, SPAN_LONG_RST};

   logic [TS_W-1:0]   now_ts = '0;

   sliding_window_share_rate u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // push one share and update the three windows
   task automatic compute_rates(input req_type r, output rsp_type e);
      logic [TS_W-1:0]  t_new;
      logic [TS_W-1:0]  t_old;
      logic [TS_W-1:0]  dur;
      logic [DEN_W-1:0] den;
      logic [95:0]      quot;
      logic             held [NWIN];
      held = '{default: 1'b0};
      share_mem[pushed_count[RING_AW-1:0]] = r.share_difficulty;
      time_mem[pushed_count[RING_AW-1:0]]  = r.timestamp_ms;
      pushed_count++;
      for (int w = 0; w < NWIN; w++) begin
         if (win_last[w] + 1 != pushed_count) begin
            win_last[w]++;
            win_sum[w] += share_mem[win_last[w][RING_AW-1:0]];
         end
         t_new = time_mem[win_last[w][RING_AW-1:0]];
         // drop oldest shares while the window still covers the span
         while (1) begin
            t_old = time_mem[win_first[w][RING_AW-1:0]];
            if ((t_new - t_old) < {16'd0, win_span[w]}) break;
            if (win_first[w] == win_last[w]) break;
            win_sum[w] -= share_mem[win_first[w][RING_AW-1:0]];
            win_first[w]++;
         end
         if (win_sum[w][SUM_W-1] || t_new == t_old) begin
            held[w] = 1'b1;
         end else begin
            dur = t_new - t_old;
            if ({16'd0, win_span[w]} > dur) dur = {16'd0, win_span[w]};
            den = dur * 58'd1000;
            if ((win_sum[w] >> 8) >= den) begin
               win_rate[w] = RATE_MAX;
            end else begin
               quot = {win_sum[w], 32'd0} / den;
               win_rate[w] = quot[RATE_W-1:0];
            end
         end
      end
      e.rate_short = win_rate[0];
      e.rate_mid   = win_rate[1];
      e.rate_long  = win_rate[2];
      e.held_short = held[0];
      e.held_mid   = held[1];
      e.held_long  = held[2];
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // request driver
   int settle_count = 0;
   always @(posedge clock) begin
      plan_entry_type p;
      if (reset) begin
         req_valid <= 1'b0;
         csr_we    <= 1'b0;
      end else if (req_valid && req_stall) begin
         // hold the stalled request
      end else if (share_plan_q.size() != 0 && share_plan_q[0].gap > 0
                   && share_plan_q[0].kind == STEP_SHARE) begin
         share_plan_q[0].gap--;
         req_valid <= 1'b0;
         csr_we    <= 1'b0;
      end else if (share_plan_q.size() == 0) begin
         req_valid <= 1'b0;
         csr_we    <= 1'b0;
      end else begin
         p = share_plan_q[0];
         case (p.kind)
            STEP_SHARE: begin
               req_valid <= 1'b1;
               req_data  <= p.share;
               csr_we    <= 1'b0;
               void'(share_plan_q.pop_front());
            end
            STEP_DRAIN: begin
               req_valid <= 1'b0;
               csr_we    <= 1'b0;
               if (!req_valid && rate_expect_q.size() == 0) begin
                  if (settle_count == SETTLE_CYCLES) begin
                     settle_count = 0;
                     void'(share_plan_q.pop_front());
                  end else begin
                     settle_count++;
                  end
               end else begin
                  settle_count = 0;
               end
            end
            default: begin
               req_valid <= 1'b0;
               csr_we    <= 1'b1;
               csr_index <= p.idx;
               csr_wdata <= p.val;
               win_span[p.idx] = p.val;
               void'(share_plan_q.pop_front());
            end
         endcase
      end
   end

   // result stall: short random stalls, occasional long ones, quiet stretches
   int stall_hold = 0;
   int stall_pct  = 25;
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      if (stall_hold > 0) begin
         stall_hold--;
         rsp_stall <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < 2) begin
         stall_hold = $urandom_range(20, 80);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // predict on accepted requests, check accepted results
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            compute_rates(req_data, e);
            rate_expect_q.push_back(e);
         end
         if (rsp_valid && !rsp_stall) begin
            if (rate_expect_q.size() == 0) begin
               report_mismatch("unexpected result", 64'(rsp_data.rate_short), 64'd0);
            end else begin
               e = rate_expect_q.pop_front();
               if (rsp_data.rate_short !== e.rate_short)
                  report_mismatch("rate_short", 64'(rsp_data.rate_short), 64'(e.rate_short));
               if (rsp_data.rate_mid !== e.rate_mid)
                  report_mismatch("rate_mid", 64'(rsp_data.rate_mid), 64'(e.rate_mid));
               if (rsp_data.rate_long !== e.rate_long)
                  report_mismatch("rate_long", 64'(rsp_data.rate_long), 64'(e.rate_long));
               if (rsp_data.held_short !== e.held_short)
                  report_mismatch("held_short", 64'(rsp_data.held_short), 64'(e.held_short));
               if (rsp_data.held_mid !== e.held_mid)
                  report_mismatch("held_mid", 64'(rsp_data.held_mid), 64'(e.held_mid));
               if (rsp_data.held_long !== e.held_long)
                  report_mismatch("held_long", 64'(rsp_data.held_long), 64'(e.held_long));
            end
         end
      end
   end

   task automatic add_share(input logic [DIFF_W-1:0] d, input logic [TS_W-1:0] ts,
                            input int gap);
      plan_entry_type p;
      p.kind  = STEP_SHARE;
      p.share = '{share_difficulty: d, timestamp_ms: ts};
      p.gap   = gap;
      p.idx   = '0;
      p.val   = '0;
      share_plan_q.push_back(p);
   endtask

   task automatic add_drain();
      plan_entry_type p;
      p.kind  = STEP_DRAIN;
      p.share = '0;
      p.gap   = 0;
      p.idx   = '0;
      p.val   = '0;
      share_plan_q.push_back(p);
   endtask

   // span writes only after the block has drained
   task automatic add_spans(input logic [SPAN_W-1:0] s0, input logic [SPAN_W-1:0] s1,
                            input logic [SPAN_W-1:0] s2);
      plan_entry_type p;
      add_drain();
      p.kind  = STEP_SPAN;
      p.share = '0;
      p.gap   = 0;
      p.idx = CSR_SPAN_SHORT; p.val = s0; share_plan_q.push_back(p);
      p.idx = CSR_SPAN_MID;   p.val = s1; share_plan_q.push_back(p);
      p.idx = CSR_SPAN_LONG;  p.val = s2; share_plan_q.push_back(p);
   endtask

   // random shares: mostly rising timestamps, some equal, a few going back
   task automatic add_random(input int count, input int max_step);
      int  pick;
      int  gap;
      bit  busy;
      logic [DIFF_W-1:0] d;
      busy = 1'b0;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) busy = ($urandom_range(0, 2) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
         end else if (pick < 12) begin
            now_ts = now_ts - TS_W'($urandom_range(1, max_step));
         end else if (pick < 14) begin
            now_ts = now_ts + TS_W'({$urandom, $urandom} % 64'd100000000);
         end else begin
            now_ts = now_ts + TS_W'($urandom_range(1, max_step));
         end
         case ($urandom_range(0, 3))
            0: d = $urandom_range(0, 1000);
            1: d = $urandom;
            2: d = ~32'd0 - $urandom_range(0, 3);
            default: d = $urandom_range(0, 1 << 20);
         endcase
         pick = $urandom_range(0, 99);
         if (busy || pick < 60) gap = 0;
         else if (pick < 92) gap = $urandom_range(1, 4);
         else gap = $urandom_range(10, 60);
         add_share(d, now_ts, gap);
      end
   endtask

   // stimulus and end of run
   initial begin
      // directed: extremes, equal and decreasing timestamps, sum wrap
      add_share(32'hFFFF_FFFF, 48'd0, 0);
      add_share(32'd0, 48'd0, 0);
      add_share(32'd1, 48'd1000, 2);
      add_share(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0);
      add_share(32'd5, 48'd5, 0);
      add_share(32'd5, 48'd5, 3);
      add_share(32'h8000_0000, 48'd700000, 0);
      add_spans(32'd1, 32'hFFFF_FFFF, 32'd1000);
      add_share(32'd10, 48'd700001, 0);
      add_share(32'hFFFF_FFFF, 48'd700002, 0);
      add_share(32'd0, 48'd700002, 0);
      add_share(32'hFFFF_FFFF, 48'd701500, 0);
      add_share(32'd3, 48'd701500, 0);
      now_ts = 48'd701500;
      add_random(140, 2000);
      add_spans(32'd50000, 32'd20000, 32'd300);
      add_random(70, 5000);
      add_drain();
      add_random(80, 500);
      add_spans(32'hFFFF_FFFF, 32'd1, 32'd7);
      now_ts = TS_W'({$urandom, $urandom});
      add_random(150, 20);
      add_spans(SPAN_SHORT_RST, SPAN_MID_RST, SPAN_LONG_RST);
      now_ts = 48'hFFFF_FFFF_0000 | 48'($urandom_range(0, 1000));
      add_random(150, 100000);
      while (share_plan_q.size() != 0 || req_valid || rate_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[sliding_window_share_rate] OK");
      end else begin
         $display("[sliding_window_share_rate] ERROR");
      end
      $finish;
   end

   // timeout
   initial begin
      #40000000;
      $display("[sliding_window_share_rate] ERROR");
      $finish;
   end

endmodule
